// ===== rtl/core/bhpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bar hit position reconstruction block.
// No dependencies.
package bhpr_pkg;

	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int TIN_W        = 31;
	localparam int WALK_W       = 21;
	localparam int HALF_W       = 20;
	localparam int KIND_W       = 2;
	localparam int ROOT_W       = 32;
	localparam int AX_W         = 41;
	localparam int CORDIC_STEPS = 15;
	localparam int ANGLE_W      = 16;
	localparam int ACC_W        = ANGLE_W + 1;

	localparam logic [ANGLE_W-1:0] HALF_PI_Q14   = 16'd25736;
	localparam logic [HALF_W:0]    IN_BAR_MARGIN = 21'd5120;

	localparam logic [KIND_W-1:0] KIND_SMALL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BIG   = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LR_OFFSET,
		REG_SOURCE_DIST,
		REG_LATERAL_OFFSET,
		REG_SMALL_HALF,
		REG_BIG_HALF,
		REG_SMALL_SPEED,
		REG_BIG_SPEED
	} cfg_reg_t;

	localparam logic [ANGLE_W-1:0] ATAN_Q14 [CORDIC_STEPS] = '{
		16'd12868, 16'd7596, 16'd4014, 16'd2037, 16'd1023, 16'd512, 16'd256, 16'd128,
		16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1
	};

	function automatic logic [4:0] msb_pos(input logic [30:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 31; i++) begin
			if (v[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/bhpr_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with side data carried along.
// Standalone; stage loads are driven by the enclosing pipeline control.
module bhpr_isqrt #(
	parameter int STEPS  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [STEPS-1:0]  en,
	input  logic [2*STEPS-1:0] rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic [STEPS-1:0]  root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = 2 * STEPS;

	logic [RW-1:0]     rem_s  [STEPS];
	logic [RW-1:0]     res_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	genvar j;
	generate
		for (j = 0; j < STEPS; j++) begin : g_step
			localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * j);
			logic [RW-1:0]     rem_i;
			logic [RW-1:0]     res_i;
			logic [RW-1:0]     trial;
			logic [SIDE_W-1:0] side_i;

			if (j == 0) begin : g_first
				assign rem_i  = rad;
				assign res_i  = '0;
				assign side_i = side_in;
			end else begin : g_next
				assign rem_i  = rem_s[j-1];
				assign res_i  = res_s[j-1];
				assign side_i = side_s[j-1];
			end

			assign trial = res_i + BIT;

			always_ff @(posedge clk) begin
				if (en[j]) begin
					side_s[j] <= side_i;
					if (rem_i >= trial) begin
						rem_s[j] <= rem_i - trial;
						res_s[j] <= (res_i >> 1) + BIT;
					end else begin
						rem_s[j] <= rem_i;
						res_s[j] <= res_i >> 1;
					end
				end
			end
		end
	endgenerate

	assign root     = res_s[STEPS-1][STEPS-1:0];
	assign side_out = side_s[STEPS-1];

endmodule

// ===== rtl/core/bhpr_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q2.14, clamped to 0..pi/2, then padded.
// Depends on bhpr_pkg.
module bhpr_cordic
	import bhpr_pkg::*;
#(
	parameter int LAT  = 32,
	parameter int IN_W = 41
) (
	input  logic               clk,
	input  logic [LAT-1:0]     en,
	input  logic [IN_W-1:0]    x_in,
	input  logic [IN_W-1:0]    y_in,
	input  logic               zero_in,
	output logic [ANGLE_W-1:0] angle
);

	localparam int CW   = IN_W + 3;
	localparam int TAIL = LAT - CORDIC_STEPS;

	logic signed [CW-1:0]    cx_s   [CORDIC_STEPS];
	logic signed [CW-1:0]    cy_s   [CORDIC_STEPS];
	logic signed [ACC_W-1:0] acc_s  [CORDIC_STEPS];
	logic                    zero_s [CORDIC_STEPS];
	logic [ANGLE_W-1:0]      ang_s  [TAIL];
	logic [ANGLE_W-1:0]      ang_d;
	logic signed [ACC_W-1:0] acc_last;

	genvar i, k;
	generate
		for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
			localparam logic signed [ACC_W-1:0] ANG = $signed({1'b0, ATAN_Q14[i]});
			logic signed [CW-1:0]    cx_i;
			logic signed [CW-1:0]    cy_i;
			logic signed [CW-1:0]    dx;
			logic signed [CW-1:0]    dy;
			logic signed [ACC_W-1:0] acc_i;
			logic                    zero_i;

			if (i == 0) begin : g_first
				assign cx_i   = $signed({3'b000, x_in});
				assign cy_i   = $signed({3'b000, y_in});
				assign acc_i  = '0;
				assign zero_i = zero_in;
			end else begin : g_next
				assign cx_i   = cx_s[i-1];
				assign cy_i   = cy_s[i-1];
				assign acc_i  = acc_s[i-1];
				assign zero_i = zero_s[i-1];
			end

			assign dx = cy_i >>> i;
			assign dy = cx_i >>> i;

			always_ff @(posedge clk) begin
				if (en[i]) begin
					zero_s[i] <= zero_i;
					if (!cy_i[CW-1]) begin
						cx_s[i]  <= cx_i + dx;
						cy_s[i]  <= cy_i - dy;
						acc_s[i] <= acc_i + ANG;
					end else begin
						cx_s[i]  <= cx_i - dx;
						cy_s[i]  <= cy_i + dy;
						acc_s[i] <= acc_i - ANG;
					end
				end
			end
		end
	endgenerate

	assign acc_last = acc_s[CORDIC_STEPS-1];

	always_comb begin
		if (zero_s[CORDIC_STEPS-1] || acc_last[ACC_W-1]) begin
			ang_d = '0;
		end else if (acc_last > $signed({1'b0, HALF_PI_Q14})) begin
			ang_d = HALF_PI_Q14;
		end else begin
			ang_d = acc_last[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[CORDIC_STEPS]) begin
			ang_s[0] <= ang_d;
		end
	end

	generate
		for (k = 1; k < TAIL; k++) begin : g_pad
			always_ff @(posedge clk) begin
				if (en[CORDIC_STEPS+k]) begin
					ang_s[k] <= ang_s[k-1];
				end
			end
		end
	endgenerate

	assign angle = ang_s[TAIL-1];

endmodule

// ===== rtl/core/bar_hit_position_reconstruct.sv =====
`timescale 1ns / 1ps
// Two-ended bar hit reconstruction: times, charge mean, in-bar flag, flight path and angle.
// Depends on bhpr_pkg, bhpr_isqrt and bhpr_cordic.
//
// One hit enters per clock and its result leaves in order, as long as the output side
// keeps taking results. Six stages form the time sums, the position along the bar and the
// squared path; the two 32-stage square roots (one result bit per stage) set the latency,
// with the angle CORDIC running alongside; one last stage registers the outputs. Every
// stage holds its own valid bit, so a stalled output only stops the stages behind a full
// one and bubbles are squeezed out. Configuration registers are read by the stages
// directly and must only be written while no hit is in flight.
module bar_hit_position_reconstruct
	import bhpr_pkg::*;
#(
	parameter int TIME_WIDTH   = 32,
	parameter int CHARGE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [TIN_W-1:0]        left_time,
	input  logic signed [TIN_W-1:0]        right_time,
	input  logic signed [WALK_W-1:0]       left_walk,
	input  logic signed [WALK_W-1:0]       right_walk,
	input  logic [CHARGE_WIDTH-1:0]        left_charge,
	input  logic [CHARGE_WIDTH-1:0]        right_charge,
	input  logic [KIND_W-1:0]              bar_kind,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [CHARGE_WIDTH-1:0]        mean_charge,
	output logic signed [TIN_W-1:0]        time_average,
	output logic signed [TIME_WIDTH-1:0]   time_difference,
	output logic signed [TIME_WIDTH-1:0]   walk_difference,
	output logic signed [TIME_WIDTH-1:0]   walk_average,
	output logic                           in_bar,
	output logic [31:0]                    path_length,
	output logic                           path_valid,
	output logic [ANGLE_W-1:0]             polar_angle
);

	localparam int PREP   = 6;
	localparam int NS     = PREP + ROOT_W + 1;
	localparam int SAT_W  = (TIME_WIDTH > 34) ? TIME_WIDTH : 34;
	localparam int SIDE_W = TIN_W + 3 * TIME_WIDTH + 2;
	localparam int PW     = 2 * CHARGE_WIDTH;
	localparam logic signed [SAT_W-1:0] SAT_HI =
		{{(SAT_W - TIME_WIDTH + 1){1'b0}}, {(TIME_WIDTH - 1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

	function automatic logic [TIME_WIDTH-1:0] sat_time(input logic signed [SAT_W-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[TIME_WIDTH-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[TIME_WIDTH-1:0];
		end
		return v[TIME_WIDTH-1:0];
	endfunction

	// configuration
	logic signed [CFG_W-1:0] lr_off_q;
	logic [CFG_W-1:0]        src_q;
	logic signed [CFG_W-1:0] lat_q;
	logic [HALF_W-1:0]       shalf_q;
	logic [HALF_W-1:0]       bhalf_q;
	logic [CFG_W-1:0]        sspd_q;
	logic [CFG_W-1:0]        bspd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_off_q <= '0;
			src_q    <= 24'd256;
			lat_q    <= '0;
			shalf_q  <= '0;
			bhalf_q  <= '0;
			sspd_q   <= '0;
			bspd_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LR_OFFSET:      lr_off_q <= cfg_data;
				REG_SOURCE_DIST:    src_q    <= cfg_data;
				REG_LATERAL_OFFSET: lat_q    <= cfg_data;
				REG_SMALL_HALF:     shalf_q  <= cfg_data[HALF_W-1:0];
				REG_BIG_HALF:       bhalf_q  <= cfg_data[HALF_W-1:0];
				REG_SMALL_SPEED:    sspd_q   <= cfg_data;
				REG_BIG_SPEED:      bspd_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage control
	logic [NS:1]   vld_q;
	logic [NS+1:1] rdy;

	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NS];

	// s1: sums and differences
	logic signed [31:0]       lw_c, rw_c;
	logic signed [31:0]       tsum_c;
	logic signed [32:0]       diff_s1;
	logic signed [33:0]       wdiff_s1;
	logic signed [32:0]       wsum_s1;
	logic signed [TIN_W-1:0]  tavg_s1;
	logic [CHARGE_WIDTH-1:0]  lq_s1, rq_s1;
	logic [KIND_W-1:0]        kind_s1;

	assign lw_c   = 32'(left_time) - 32'(left_walk);
	assign rw_c   = 32'(right_time) - 32'(right_walk);
	assign tsum_c = 32'(left_time) + 32'(right_time);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			diff_s1  <= 33'(left_time) - 33'(right_time) + 33'(lr_off_q);
			wdiff_s1 <= 34'(lw_c) - 34'(rw_c) + 34'(lr_off_q);
			wsum_s1  <= 33'(lw_c) + 33'(rw_c);
			tavg_s1  <= tsum_c[31:1];
			lq_s1    <= left_charge;
			rq_s1    <= right_charge;
			kind_s1  <= bar_kind;
		end
	end

	// s2: saturation, in-bar test, position product
	logic                     kval_c, big_c;
	logic [HALF_W-1:0]        half_c;
	logic [CFG_W-1:0]         spd_c;
	logic signed [32:0]       dneg_c;
	logic [32:0]              adiff_c;
	logic [HALF_W:0]          lim_c;
	logic                     inbar_c;
	logic signed [57:0]       mul_c;
	logic [SIDE_W-1:0]        side_s2;
	logic signed [57:0]       mul_s2;
	logic [CHARGE_WIDTH-1:0]  lq_s2, rq_s2;

	assign kval_c  = (kind_s1 == KIND_SMALL) || (kind_s1 == KIND_BIG);
	assign big_c   = (kind_s1 == KIND_BIG);
	assign half_c  = big_c ? bhalf_q : shalf_q;
	assign spd_c   = big_c ? bspd_q : sspd_q;
	assign dneg_c  = -diff_s1;
	assign adiff_c = diff_s1[32] ? dneg_c : diff_s1;
	assign lim_c   = 21'(half_c) + IN_BAR_MARGIN;
	assign inbar_c = kval_c && (adiff_c < 33'(lim_c));
	assign mul_c   = 58'($signed({1'b0, spd_c})) * 58'(diff_s1);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			side_s2 <= {tavg_s1,
				sat_time(SAT_W'(diff_s1)),
				sat_time(SAT_W'(wdiff_s1)),
				sat_time(SAT_W'($signed(wsum_s1[32:1]))),
				inbar_c, kval_c};
			mul_s2  <= mul_c;
			lq_s2   <= lq_s1;
			rq_s2   <= rq_s1;
		end
	end

	// s3: position along the bar
	logic signed [41:0]       x_s3;
	logic [SIDE_W-1:0]        side_s3;
	logic [CHARGE_WIDTH-1:0]  lq_s3, rq_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			x_s3    <= 42'($signed(mul_s2[57:17])) + 42'(lat_q);
			side_s3 <= side_s2;
			lq_s3   <= lq_s2;
			rq_s3   <= rq_s2;
		end
	end

	// s4: magnitude
	logic signed [41:0]       xabs_c;
	logic [AX_W-1:0]          ax_s4;
	logic [SIDE_W-1:0]        side_s4;
	logic [CHARGE_WIDTH-1:0]  lq_s4, rq_s4;

	assign xabs_c = x_s3[41] ? -x_s3 : x_s3;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			ax_s4   <= xabs_c[AX_W-1:0];
			side_s4 <= side_s3;
			lq_s4   <= lq_s3;
			rq_s4   <= rq_s3;
		end
	end

	// s5: squares, charge product, normalization count
	logic                     small_c;
	logic [4:0]               nrm_c;
	logic [63:0]              xx_s5;
	logic [47:0]              zz_s5;
	logic                     ovf_s5;
	logic [4:0]               nrm_s5;
	logic                     zero_s5;
	logic [AX_W-1:0]          ax_s5;
	logic [PW-1:0]            prod_s5;
	logic [SIDE_W-1:0]        side_s5;

	assign small_c = ~|ax_s4[AX_W-1:30];
	assign nrm_c   = small_c ? 5'd30 - msb_pos({1'b0, ax_s4[29:0] | 30'(src_q)}) : 5'd0;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			xx_s5   <= 64'(ax_s4[31:0]) * 64'(ax_s4[31:0]);
			zz_s5   <= 48'(src_q) * 48'(src_q);
			ovf_s5  <= |ax_s4[AX_W-1:32];
			nrm_s5  <= nrm_c;
			zero_s5 <= (ax_s4 == '0) && (src_q == '0);
			ax_s5   <= ax_s4;
			prod_s5 <= PW'(lq_s4) * PW'(rq_s4);
			side_s5 <= side_s4;
		end
	end

	// s6: path radicand, CORDIC operands
	logic [64:0]              psum_c;
	logic [63:0]              sum_s6;
	logic                     ovf_s6;
	logic [AX_W-1:0]          cx_s6, cy_s6;
	logic                     zero_s6;
	logic [PW-1:0]            prod_s6;
	logic [SIDE_W-1:0]        side_s6;

	assign psum_c = 65'(xx_s5) + 65'(zz_s5);

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			sum_s6  <= psum_c[63:0];
			ovf_s6  <= ovf_s5 | psum_c[64];
			cx_s6   <= AX_W'(src_q) << nrm_s5;
			cy_s6   <= ax_s5 << nrm_s5;
			zero_s6 <= zero_s5;
			prod_s6 <= prod_s5;
			side_s6 <= side_s5;
		end
	end

	// square roots and angle
	logic [ROOT_W-1:0]  proot, qroot;
	logic [SIDE_W-1:0]  side_o;
	logic               ovf_o;
	logic [ANGLE_W-1:0] ang_o;

	bhpr_isqrt #(
		.STEPS  (ROOT_W),
		.SIDE_W (SIDE_W)
	) u_path_sqrt (
		.clk      (clk),
		.en       (rdy[PREP+ROOT_W:PREP+1]),
		.rad      (sum_s6),
		.side_in  (side_s6),
		.root     (proot),
		.side_out (side_o)
	);

	bhpr_isqrt #(
		.STEPS  (ROOT_W),
		.SIDE_W (1)
	) u_charge_sqrt (
		.clk      (clk),
		.en       (rdy[PREP+ROOT_W:PREP+1]),
		.rad      ((2 * ROOT_W)'(prod_s6)),
		.side_in  (ovf_s6),
		.root     (qroot),
		.side_out (ovf_o)
	);

	bhpr_cordic #(
		.LAT  (ROOT_W),
		.IN_W (AX_W)
	) u_cordic (
		.clk     (clk),
		.en      (rdy[PREP+ROOT_W:PREP+1]),
		.x_in    (cx_s6),
		.y_in    (cy_s6),
		.zero_in (zero_s6),
		.angle   (ang_o)
	);

	// output register
	logic signed [TIN_W-1:0]      f_tavg;
	logic [TIME_WIDTH-1:0]        f_tdiff, f_wdiff, f_wavg;
	logic                         f_inbar, f_kval;

	assign {f_tavg, f_tdiff, f_wdiff, f_wavg, f_inbar, f_kval} = side_o;

	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			mean_charge     <= qroot[CHARGE_WIDTH-1:0];
			time_average    <= f_tavg;
			time_difference <= f_tdiff;
			walk_difference <= f_wdiff;
			walk_average    <= f_wavg;
			in_bar          <= f_inbar;
			path_valid      <= f_kval;
			path_length     <= !f_kval ? 32'd0 : (ovf_o ? 32'hFFFF_FFFF : proot);
			polar_angle     <= f_kval ? ang_o : '0;
		end
	end

endmodule

// ===== tb/bar_hit_checker.sv =====
`timescale 1ns / 1ps
// Checker for bar_hit_position_reconstruct: watches the hit and result transfers,
// predicts each result from its own copy of the registers and compares. Depends on bhpr_pkg.
module bar_hit_checker
	import bhpr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [30:0]       left_time,
	input  logic signed [30:0]       right_time,
	input  logic signed [20:0]       left_walk,
	input  logic signed [20:0]       right_walk,
	input  logic [23:0]              left_charge,
	input  logic [23:0]              right_charge,
	input  logic [1:0]               bar_kind,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [23:0]              mean_charge,
	input  logic signed [30:0]       time_average,
	input  logic signed [31:0]       time_difference,
	input  logic signed [31:0]       walk_difference,
	input  logic signed [31:0]       walk_average,
	input  logic                     in_bar,
	input  logic [31:0]              path_length,
	input  logic                     path_valid,
	input  logic [15:0]              polar_angle,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic [23:0] mean_charge;
		logic [30:0] time_average;
		logic [31:0] time_difference;
		logic [31:0] walk_difference;
		logic [31:0] walk_average;
		logic        in_bar;
		logic [31:0] path_length;
		logic        path_valid;
		logic [15:0] polar_angle;
	} hit_result_t;

	hit_result_t expected_hits[$];

	logic signed [63:0] lr_offset, lat_offset;
	logic [63:0] src_dist, small_half, big_half, small_speed, big_speed;

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [15:0] cordic_angle(input logic [63:0] x, input logic [63:0] y);
		logic signed [63:0] cx, cy, dx, dy, acc;
		acc = 0;
		if (x == 0 && y == 0) return 16'd0;
		while (x < (64'd1 << 30) && y < (64'd1 << 30)) begin
			x = x << 1;
			y = y << 1;
		end
		cx = x;
		cy = y;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx = cx + dx; cy = cy - dy; acc = acc + ATAN_Q14[i];
			end else begin
				cx = cx - dx; cy = cy + dy; acc = acc - ATAN_Q14[i];
			end
		end
		if (acc < 0) acc = 0;
		if (acc > HALF_PI_Q14) acc = HALF_PI_Q14;
		return acc[15:0];
	endfunction

	function automatic hit_result_t reconstruct_hit(input logic signed [30:0] lt,
			input logic signed [30:0] rt, input logic signed [20:0] lwk,
			input logic signed [20:0] rwk, input logic [23:0] lq, input logic [23:0] rq,
			input logic [1:0] kind);
		hit_result_t r;
		logic signed [63:0] lw, rw, diff, wdiff, x, sum_t;
		logic [63:0] adiff, ax, half, speed, xx, total, path;
		lw = 64'(lt) - 64'(lwk);
		rw = 64'(rt) - 64'(rwk);
		diff = 64'(lt) - 64'(rt) + lr_offset;
		wdiff = lw - rw + lr_offset;
		sum_t = 64'(lt) + 64'(rt);
		r = '0;
		r.mean_charge = 24'(int_sqrt(64'(lq) * 64'(rq)));
		r.time_average = 31'(sum_t >>> 1);
		r.time_difference = 32'(sat32(diff));
		r.walk_difference = 32'(sat32(wdiff));
		r.walk_average = 32'(sat32((lw + rw) >>> 1));
		if (kind == KIND_SMALL || kind == KIND_BIG) begin
			half = (kind == KIND_SMALL) ? small_half : big_half;
			speed = (kind == KIND_SMALL) ? small_speed : big_speed;
			adiff = (diff < 0) ? -diff : diff;
			x = (($signed(speed) * diff) >>> 17) + lat_offset;
			ax = (x < 0) ? -x : x;
			r.path_valid = 1'b1;
			r.in_bar = adiff < half + IN_BAR_MARGIN;
			if (ax >= (64'd1 << 32)) begin
				path = 64'hFFFF_FFFF;
			end else begin
				xx = ax * ax;
				total = xx + src_dist * src_dist;
				path = (total < xx) ? 64'hFFFF_FFFF : int_sqrt(total);
				if (path > 64'hFFFF_FFFF) path = 64'hFFFF_FFFF;
			end
			r.path_length = path[31:0];
			r.polar_angle = cordic_angle(src_dist, ax);
		end
		return r;
	endfunction

	hit_result_t seen, want;

	assign pending = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_offset <= 0; src_dist <= 256; lat_offset <= 0;
			small_half <= 0; big_half <= 0; small_speed <= 0; big_speed <= 0;
			fail_count <= 0;
			expected_hits.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
				REG_LR_OFFSET: lr_offset <= 64'($signed(cfg_data));
				REG_SOURCE_DIST: src_dist <= 64'(cfg_data);
				REG_LATERAL_OFFSET: lat_offset <= 64'($signed(cfg_data));
				REG_SMALL_HALF: small_half <= 64'(cfg_data[19:0]);
				REG_BIG_HALF: big_half <= 64'(cfg_data[19:0]);
				REG_SMALL_SPEED: small_speed <= 64'(cfg_data);
				REG_BIG_SPEED: big_speed <= 64'(cfg_data);
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_hits.push_back(reconstruct_hit(left_time, right_time, left_walk,
					right_walk, left_charge, right_charge, bar_kind));
			if (out_valid && out_ready) begin
				seen = '{mean_charge, time_average, time_difference, walk_difference,
					walk_average, in_bar, path_length, path_valid, polar_angle};
				if (expected_hits.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer: %h", seen);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (seen !== want) begin
						if (fail_count < 10)
							$display("mismatch: exp %p\n          got %p", want, seen);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/bar_hit_position_reconstruct_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for bar_hit_position_reconstruct: directed and random hits under
// several register settings and idle patterns. Also depends on bhpr_pkg and bar_hit_checker.
module bar_hit_position_reconstruct_tb;
	import bhpr_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic out_ready = 0;
	logic signed [30:0] left_time = 0, right_time = 0;
	logic signed [20:0] left_walk = 0, right_walk = 0;
	logic [23:0] left_charge = 0, right_charge = 0;
	logic [1:0] bar_kind = 0;
	logic in_ready, out_valid, in_bar, path_valid;
	logic [23:0] mean_charge;
	logic signed [30:0] time_average;
	logic signed [31:0] time_difference, walk_difference, walk_average;
	logic [31:0] path_length;
	logic [15:0] polar_angle;
	int fail_count, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;
	longint cycle_count = 0;

	always #10 clk = ~clk;

	bar_hit_position_reconstruct u_top (.*);
	bar_hit_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// drive one hit at a falling edge, hold until transfer
	task automatic send_hit(input logic [30:0] lt, input logic [30:0] rt,
			input logic [20:0] lw, input logic [20:0] rw, input logic [23:0] lq,
			input logic [23:0] rq, input logic [1:0] kind);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		left_time <= lt; right_time <= rt; left_walk <= lw; right_walk <= rw;
		left_charge <= lq; right_charge <= rq; bar_kind <= kind;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_hit();
		logic [30:0] lt, rt;
		logic [23:0] lq, rq;
		lt = 31'($urandom);
		rt = ($urandom_range(3) == 0) ? 31'($urandom) : lt + 31'($signed($urandom_range(20000)) - 10000);
		lq = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(4000));
		rq = 24'($urandom);
		send_hit(lt, rt, 21'($urandom), 21'($urandom), lq, rq, 2'($urandom_range(3)));
	endtask

	task automatic random_config();
		write_reg(REG_LR_OFFSET, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(2000)));
		write_reg(REG_SOURCE_DIST, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(60000)));
		write_reg(REG_LATERAL_OFFSET, 24'($urandom));
		write_reg(REG_SMALL_HALF, 24'($urandom));
		write_reg(REG_BIG_HALF, 24'($urandom_range(30000)));
		write_reg(REG_SMALL_SPEED, 24'($urandom));
		write_reg(REG_BIG_SPEED, 24'($urandom_range(2000000)));
	endtask

	initial begin
		int mode;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		recv_stall_pct = 0;
		// directed: extremes of fields and all kinds at reset settings
		send_hit(31'h3FFFFFFF, 31'h40000000, 21'h0FFFFF, 21'h100000, 24'hFFFFFF, 24'hFFFFFF, 0);
		send_hit(31'h40000000, 31'h3FFFFFFF, 21'h100000, 21'h0FFFFF, 0, 24'hFFFFFF, 1);
		send_hit(0, 0, 0, 0, 0, 0, 2);
		send_hit(100, 100, 5, -21'sd5, 9, 16, 3);
		send_hit(31'h7FFFFFFF, 0, 0, 0, 1, 1, 0);
		drain();
		// extreme settings: zero source distance, full speeds and offsets
		write_reg(REG_LR_OFFSET, 24'h7FFFFF);
		write_reg(REG_SOURCE_DIST, 0);
		write_reg(REG_LATERAL_OFFSET, 24'h800000);
		write_reg(REG_SMALL_HALF, 24'hFFFFF);
		write_reg(REG_BIG_HALF, 0);
		write_reg(REG_SMALL_SPEED, 24'hFFFFFF);
		write_reg(REG_BIG_SPEED, 24'hFFFFFF);
		send_hit(31'h3FFFFFFF, 31'h40000000, 0, 0, 5, 5, 0);
		send_hit(31'h40000000, 31'h3FFFFFFF, 0, 0, 5, 5, 1);
		send_hit(0, 0, 0, 0, 5, 5, 1);
		send_hit(-31'sd5120, 0, 0, 0, 5, 5, 0);
		drain();
		write_reg(REG_LR_OFFSET, 24'h800000);
		write_reg(REG_SOURCE_DIST, 24'hFFFFFF);
		write_reg(REG_LATERAL_OFFSET, 24'h7FFFFF);
		write_reg(REG_SMALL_SPEED, 0);
		send_hit(0, 0, 0, 0, 5, 5, 0);
		send_hit(5119, 0, 0, 0, 5, 5, 1);
		send_hit(0, 0, 0, 0, 5, 5, 2);
		drain();
		write_reg(REG_SOURCE_DIST, 0);
		write_reg(REG_LATERAL_OFFSET, 0);
		write_reg(REG_LR_OFFSET, 0);
		send_hit(0, 0, 0, 0, 5, 5, 0);
		drain();
		for (int phase = 0; phase < 9; phase++) begin
			mode = phase % 4;
			send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 21 : 47) : 0;
			recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 21 : 47) : 0;
			random_config();
			for (int n = 0; n < 100; n++) begin
				random_hit();
				if (n == 50 && phase == 4) begin
					in_valid <= 0;
					while (pending != 0) @(negedge clk);
				end
			end
			drain();
		end
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
